FILE: rtl/vdf_pkg.sv
// Shared widths, register codes, constants and the result beat type.
package vdf_pkg;

   localparam int CSR_W    = 12;
   localparam int PIX_W    = 8;
   localparam int PLANE_W  = 2;
   localparam int COORD_W  = 11;
   localparam int CSR_IDX_W = 2;

   localparam int MAX_WIDTH_DEFAULT  = 2048;
   localparam int MAX_HEIGHT_DEFAULT = 2048;

   localparam logic [CSR_W-1:0] LUMA_WIDTH_RESET    = CSR_W'(720);
   localparam logic [CSR_W-1:0] LUMA_HEIGHT_RESET   = CSR_W'(576);
   localparam logic [CSR_W-1:0] CHROMA_WIDTH_RESET  = CSR_W'(360);
   localparam logic [CSR_W-1:0] CHROMA_HEIGHT_RESET = CSR_W'(288);

   localparam logic [PIX_W:0] DIFF_OFFSET = (PIX_W+1)'(16);
   localparam logic [PIX_W:0] PIX_MAX     = (PIX_W+1)'(255);

   localparam logic [PLANE_W-1:0] PLANE_LUMA = PLANE_W'(0);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_LUMA_WIDTH    = 2'd0,
      CSR_LUMA_HEIGHT   = 2'd1,
      CSR_CHROMA_WIDTH  = 2'd2,
      CSR_CHROMA_HEIGHT = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [PIX_W-1:0]   pixel;
      logic [PLANE_W-1:0] plane;
      logic [COORD_W-1:0] column;
      logic [COORD_W-1:0] row;
      logic               last;
   } rsp_beat_type;

endpackage

FILE: rtl/vdf_if.sv
// Valid/ready channel interfaces for pixel requests and filter results.
interface vdf_req_if;
   logic                          valid;
   logic                          ready;
   logic [vdf_pkg::PLANE_W-1:0]   plane_index;
   logic [vdf_pkg::PIX_W-1:0]     pixel_in;

   modport source (output valid, output plane_index, output pixel_in, input ready);
   modport sink   (input valid, input plane_index, input pixel_in, output ready);
endinterface

interface vdf_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [vdf_pkg::PIX_W-1:0]     pixel_out;
   logic [vdf_pkg::PLANE_W-1:0]   plane_out;
   logic [vdf_pkg::COORD_W-1:0]   column_out;
   logic [vdf_pkg::COORD_W-1:0]   row_out;
   logic                          last_of_run;

   modport source (output valid, output pixel_out, output plane_out, output column_out,
                   output row_out, output last_of_run, input ready);
   modport sink   (input valid, input pixel_out, input plane_out, input column_out,
                   input row_out, input last_of_run, output ready);
endinterface

FILE: rtl/vdf_line_ram.sv
// One-line pixel store: one write and one registered read per cycle.
module vdf_line_ram #(
   parameter int DEPTH = vdf_pkg::MAX_WIDTH_DEFAULT
) (
   input  logic                        clock,
   input  logic                        wr_en,
   input  logic [$clog2(DEPTH)-1:0]    wr_addr,
   input  logic [vdf_pkg::PIX_W-1:0]   wr_data,
   input  logic                        rd_en,
   input  logic [$clog2(DEPTH)-1:0]    rd_addr,
   output logic [vdf_pkg::PIX_W-1:0]   rd_data
);

   logic [vdf_pkg::PIX_W-1:0] mem_ff [DEPTH];
   logic [vdf_pkg::PIX_W-1:0] rd_data_ff;

   // read returns the old entry when the same address is written this cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/vertical_difference_filter_core.sv
// An accepted pixel is registered in stage 1, and its result beat then in the output register.
// Throughput: one pixel per cycle while results are taken; a pixel on the last
// row of a plane with more than one row yields two result beats and stalls input.
// The line store takes one read and one write per pixel, which sets that rate.
// Reset (synchronous, active high) clears counters, pipeline valids and
// restores the register defaults; the line store is not cleared.
module vertical_difference_filter_core #(
   parameter int MAX_WIDTH  = vdf_pkg::MAX_WIDTH_DEFAULT,
   parameter int MAX_HEIGHT = vdf_pkg::MAX_HEIGHT_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   vdf_req_if.sink                         req_chan,
   vdf_rsp_if.source                       rsp_chan,
   input  logic                            csr_we,
   input  logic [vdf_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [vdf_pkg::CSR_W-1:0]       csr_wdata
);

   localparam int XW   = $clog2(MAX_WIDTH);
   localparam int YW   = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
   localparam int MAXD = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
   localparam int DW0  = $clog2(MAXD + 1);
   localparam int CMW  = ((DW0 > vdf_pkg::CSR_W) ? DW0 : vdf_pkg::CSR_W) + 1;
   localparam int XBW  = (XW > vdf_pkg::COORD_W) ? XW : vdf_pkg::COORD_W;
   localparam int YBW  = (YW > vdf_pkg::COORD_W) ? YW : vdf_pkg::COORD_W;

   // configuration registers
   logic [vdf_pkg::CSR_W-1:0] luma_w_ff, luma_h_ff, chroma_w_ff, chroma_h_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         luma_w_ff   <= vdf_pkg::LUMA_WIDTH_RESET;
         luma_h_ff   <= vdf_pkg::LUMA_HEIGHT_RESET;
         chroma_w_ff <= vdf_pkg::CHROMA_WIDTH_RESET;
         chroma_h_ff <= vdf_pkg::CHROMA_HEIGHT_RESET;
      end else if (csr_we) begin
         case (vdf_pkg::csr_index_type'(csr_index))
            vdf_pkg::CSR_LUMA_WIDTH:    luma_w_ff   <= csr_wdata;
            vdf_pkg::CSR_LUMA_HEIGHT:   luma_h_ff   <= csr_wdata;
            vdf_pkg::CSR_CHROMA_WIDTH:  chroma_w_ff <= csr_wdata;
            vdf_pkg::CSR_CHROMA_HEIGHT: chroma_h_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // handshake control
   logic s1_valid_ff, s1_valid_in;
   logic out_valid_ff, out_valid_in;
   logic pend_valid_ff, pend_valid_in;
   logic s1_diff_ff, s1_pass_ff;
   logic s1_has, out_free, s1_move, accept, out_load, out_pop;

   assign s1_has   = s1_diff_ff | s1_pass_ff;
   assign out_free = !out_valid_ff || (rsp_chan.ready && !pend_valid_ff);
   assign s1_move  = s1_valid_ff && (!s1_has || out_free);
   assign req_chan.ready = !s1_valid_ff || s1_move;
   assign accept   = req_chan.valid && req_chan.ready;
   assign out_load = s1_move && s1_has;
   assign out_pop  = out_valid_ff && rsp_chan.ready;

   // position counters
   logic [XW-1:0] col_ff, col_in;
   logic [YW-1:0] row_ff, row_in;
   logic [CMW-1:0] w_b, h_b, w_c, h_c, col_c, row_c, ncol_c, nrow_c;
   logic [XW-1:0] x_pos;
   logic [YW-1:0] y_pos;
   logic do_diff, do_pass;

   always_comb begin
      if (req_chan.plane_index == vdf_pkg::PLANE_LUMA) begin
         w_c = CMW'(luma_w_ff);
         h_c = CMW'(luma_h_ff);
      end else begin
         w_c = CMW'(chroma_w_ff);
         h_c = CMW'(chroma_h_ff);
      end
      if (w_c == '0) begin
         w_b = CMW'(1);
      end else if (w_c > CMW'(MAX_WIDTH)) begin
         w_b = CMW'(MAX_WIDTH);
      end else begin
         w_b = w_c;
      end
      if (h_c == '0) begin
         h_b = CMW'(1);
      end else if (h_c > CMW'(MAX_HEIGHT)) begin
         h_b = CMW'(MAX_HEIGHT);
      end else begin
         h_b = h_c;
      end

      // wrap stale counters left by a register write or a plane switch
      col_c = CMW'(col_ff);
      row_c = CMW'(row_ff);
      if (col_c >= w_b) begin
         col_c = '0;
         row_c = row_c + CMW'(1);
      end
      if (row_c >= h_b) begin
         row_c = '0;
      end

      do_diff = (row_c != '0);
      do_pass = (row_c == h_b - CMW'(1));

      ncol_c = col_c + CMW'(1);
      nrow_c = row_c;
      if (ncol_c >= w_b) begin
         ncol_c = '0;
         nrow_c = row_c + CMW'(1);
         if (nrow_c >= h_b) begin
            nrow_c = '0;
         end
      end

      x_pos  = col_c[XW-1:0];
      y_pos  = row_c[YW-1:0];
      col_in = accept ? ncol_c[XW-1:0] : col_ff;
      row_in = accept ? nrow_c[YW-1:0] : row_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // line store: read the pixel above, overwrite it with this one
   logic [vdf_pkg::PIX_W-1:0] above;

   vdf_line_ram #(
      .DEPTH (MAX_WIDTH)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (accept),
      .wr_addr (x_pos),
      .wr_data (req_chan.pixel_in),
      .rd_en   (accept),
      .rd_addr (x_pos),
      .rd_data (above)
   );

   // stage 1: accepted pixel and its position
   logic [vdf_pkg::PLANE_W-1:0] s1_plane_ff;
   logic [vdf_pkg::PIX_W-1:0]   s1_pix_ff;
   logic [XW-1:0]               s1_x_ff;
   logic [YW-1:0]               s1_y_ff;

   assign s1_valid_in = accept || (s1_valid_ff && !s1_move);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_plane_ff <= req_chan.plane_index;
         s1_pix_ff   <= req_chan.pixel_in;
         s1_x_ff     <= x_pos;
         s1_y_ff     <= y_pos;
         s1_diff_ff  <= do_diff;
         s1_pass_ff  <= do_pass;
      end
   end

   // difference and result beats
   logic [vdf_pkg::PIX_W-1:0] abs_diff;
   logic [vdf_pkg::PIX_W:0]   diff_sum;
   logic [XBW-1:0]            x_wide;
   logic [YBW-1:0]            y_wide, y_up_wide;
   vdf_pkg::rsp_beat_type     diff_beat, pass_beat, first_beat;

   always_comb begin
      abs_diff = (above > s1_pix_ff) ? (above - s1_pix_ff) : (s1_pix_ff - above);
      diff_sum = {1'b0, abs_diff} + vdf_pkg::DIFF_OFFSET;
      x_wide    = XBW'(s1_x_ff);
      y_wide    = YBW'(s1_y_ff);
      y_up_wide = YBW'(s1_y_ff - YW'(1));

      diff_beat.pixel  = (diff_sum > vdf_pkg::PIX_MAX) ?
                         vdf_pkg::PIX_MAX[vdf_pkg::PIX_W-1:0] :
                         diff_sum[vdf_pkg::PIX_W-1:0];
      diff_beat.plane  = s1_plane_ff;
      diff_beat.column = x_wide[vdf_pkg::COORD_W-1:0];
      diff_beat.row    = y_up_wide[vdf_pkg::COORD_W-1:0];
      diff_beat.last   = !s1_pass_ff;

      pass_beat.pixel  = s1_pix_ff;
      pass_beat.plane  = s1_plane_ff;
      pass_beat.column = x_wide[vdf_pkg::COORD_W-1:0];
      pass_beat.row    = y_wide[vdf_pkg::COORD_W-1:0];
      pass_beat.last   = 1'b1;

      first_beat = s1_diff_ff ? diff_beat : pass_beat;
   end

   // output register plus one pending pass-through beat
   vdf_pkg::rsp_beat_type out_ff, out_in, pend_ff, pend_in;

   always_comb begin
      out_valid_in  = out_valid_ff;
      pend_valid_in = pend_valid_ff;
      out_in        = out_ff;
      pend_in       = pend_ff;
      if (out_load) begin
         out_valid_in  = 1'b1;
         out_in        = first_beat;
         pend_valid_in = s1_diff_ff && s1_pass_ff;
         pend_in       = pass_beat;
      end else if (out_pop) begin
         out_valid_in  = pend_valid_ff;
         out_in        = pend_ff;
         pend_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         pend_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         pend_valid_ff <= pend_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      pend_ff <= pend_in;
   end

   assign rsp_chan.valid       = out_valid_ff;
   assign rsp_chan.pixel_out   = out_ff.pixel;
   assign rsp_chan.plane_out   = out_ff.plane;
   assign rsp_chan.column_out  = out_ff.column;
   assign rsp_chan.row_out     = out_ff.row;
   assign rsp_chan.last_of_run = out_ff.last;

endmodule

FILE: rtl/vdf_checker.sv
// Port-level assertions for the filter core and the bind that attaches them.
module vdf_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [vdf_pkg::PIX_W-1:0]     rsp_pixel_out,
   input logic [vdf_pkg::COORD_W-1:0]   rsp_column_out,
   input logic                          rsp_last_of_run
);

   // a stalled result beat holds its payload
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_pixel_out)
                                  && $stable(rsp_column_out))
      else $error("rsp beat changed while stalled");

   // no result right after reset
   assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("rsp valid right after reset");

   // the pass-through beat follows a non-final beat in the next cycle
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last_of_run |=> rsp_valid && rsp_last_of_run)
      else $error("pass-through beat missing after difference beat");

   // the two beats of one pixel share the column
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last_of_run |=>
         rsp_column_out == $past(rsp_column_out))
      else $error("column changed between beats of one pixel");

   // a difference beat that is not the last of its run carries at least the offset
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last_of_run |->
         ({1'b0, rsp_pixel_out} >= vdf_pkg::DIFF_OFFSET))
      else $error("difference beat below offset");

endmodule

bind vertical_difference_filter_core vdf_checker u_vdf_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_chan.valid),
   .rsp_ready       (rsp_chan.ready),
   .rsp_pixel_out   (rsp_chan.pixel_out),
   .rsp_column_out  (rsp_chan.column_out),
   .rsp_last_of_run (rsp_chan.last_of_run)
);

FILE: tb/sv/testbench.sv
// Self-checking bench for the vertical difference filter: directed table, then random frames.
`timescale 1ns / 1ps

module testbench;
   import vdf_pkg::*;

   localparam int MAX_W          = MAX_WIDTH_DEFAULT;
   localparam int MAX_H          = MAX_HEIGHT_DEFAULT;
   localparam int RANDOM_ITEMS   = 1350;
   localparam int FILL_WIDTH     = 256;
   localparam int SETTLE_CYCLES  = 6;
   localparam int HOLD_AFTER     = 150;
   localparam int HOLD_CYCLES    = 300;
   localparam int LIMIT_NS       = 10_000_000;
   localparam int DIR_ROWS       = 22;

   localparam logic [PLANE_W-1:0] PLANE_CB    = PLANE_W'(1);
   localparam logic [PLANE_W-1:0] PLANE_CR    = PLANE_W'(2);
   localparam logic [PLANE_W-1:0] PLANE_EXTRA = PLANE_W'(3);

   typedef enum logic {ROW_PIXEL, ROW_CSR} row_kind_type;

   typedef struct packed {
      row_kind_type       kind;
      csr_index_type      csr_idx;
      logic [CSR_W-1:0]   csr_val;
      logic [PLANE_W-1:0] plane;
      logic [PIX_W-1:0]   pixel;
      logic               typed;
      logic [1:0]         n_typed;
      rsp_beat_type       first_beat;
      rsp_beat_type       second_beat;
   } stim_row_type;

   // Rows marked typed carry their results; the rest go through the filter model.
   stim_row_type directed_rows [DIR_ROWS] = '{
      '{ROW_PIXEL, CSR_LUMA_WIDTH, 12'd0, PLANE_LUMA, 8'hFF, 1'b1, 2'd0, '0, '0},
      '{ROW_CSR, CSR_LUMA_WIDTH, 12'd0, PLANE_LUMA, 8'h00, 1'b0, 2'd0, '0, '0},
      '{ROW_PIXEL, CSR_LUMA_WIDTH, 12'd0, PLANE_LUMA, 8'h00, 1'b1, 2'd1,
        '{8'hFF, PLANE_LUMA, 11'd0, 11'd0, 1'b1}, '0},
      '{ROW_CSR, CSR_LUMA_HEIGHT, 12'd0, PLANE_LUMA, 8'h00, 1'b0, 2'd0, '0, '0},
      '{ROW_PIXEL, CSR_LUMA_WIDTH, 12'd0, PLANE_LUMA, 8'hAA, 1'b1, 2'd1,
        '{8'hAA, PLANE_LUMA, 11'd0, 11'd0, 1'b1}, '0},
      '{ROW_CSR, CSR_CHROMA_WIDTH, 12'd2, PLANE_LUMA, 8'h00, 1'b0, 2'd0, '0, '0},
      '{ROW_CSR, CSR_CHROMA_HEIGHT, 12'd2, PLANE_LUMA, 8'h00, 1'b0, 2'd0, '0, '0},
      '{ROW_PIXEL, CSR_LUMA_WIDTH, 12'd0, PLANE_EXTRA, 8'h10, 1'b1, 2'd0, '0, '0},
      '{ROW_PIXEL, CSR_LUMA_WIDTH, 12'd0, PLANE_EXTRA, 8'h20, 1'b1, 2'd0, '0, '0},
      '{ROW_PIXEL, CSR_LUMA_WIDTH, 12'd0, PLANE_EXTRA, 8'h00, 1'b1, 2'd2,
        '{8'h20, PLANE_EXTRA, 11'd0, 11'd0, 1'b0},
        '{8'h00, PLANE_EXTRA, 11'd0, 11'd1, 1'b1}},
      '{ROW_PIXEL, CSR_LUMA_WIDTH, 12'd0, PLANE_CB, 8'hFF, 1'b1, 2'd2,
        '{8'hEF, PLANE_CB, 11'd1, 11'd0, 1'b0},
        '{8'hFF, PLANE_CB, 11'd1, 11'd1, 1'b1}},
      '{ROW_PIXEL, CSR_LUMA_WIDTH, 12'd0, PLANE_CR, 8'h80, 1'b1, 2'd0, '0, '0},
      '{ROW_PIXEL, CSR_LUMA_WIDTH, 12'd0, PLANE_LUMA, 8'h00, 1'b1, 2'd1,
        '{8'h00, PLANE_LUMA, 11'd0, 11'd0, 1'b1}, '0},
      '{ROW_CSR, CSR_LUMA_WIDTH, 12'hFFF, PLANE_LUMA, 8'h00, 1'b0, 2'd0, '0, '0},
      '{ROW_CSR, CSR_LUMA_HEIGHT, 12'hFFF, PLANE_LUMA, 8'h00, 1'b0, 2'd0, '0, '0},
      '{ROW_PIXEL, CSR_LUMA_WIDTH, 12'd0, PLANE_LUMA, 8'h7F, 1'b1, 2'd0, '0, '0},
      '{ROW_PIXEL, CSR_LUMA_WIDTH, 12'd0, PLANE_LUMA, 8'h01, 1'b1, 2'd0, '0, '0},
      '{ROW_CSR, CSR_LUMA_WIDTH, 12'd2, PLANE_LUMA, 8'h00, 1'b0, 2'd0, '0, '0},
      '{ROW_PIXEL, CSR_LUMA_WIDTH, 12'd0, PLANE_LUMA, 8'h8F, 1'b0, 2'd0, '0, '0},
      '{ROW_PIXEL, CSR_LUMA_WIDTH, 12'd0, PLANE_LUMA, 8'h01, 1'b0, 2'd0, '0, '0},
      '{ROW_CSR, CSR_LUMA_HEIGHT, 12'd2, PLANE_LUMA, 8'h00, 1'b0, 2'd0, '0, '0},
      '{ROW_PIXEL, CSR_LUMA_WIDTH, 12'd0, PLANE_LUMA, 8'h33, 1'b0, 2'd0, '0, '0}
   };

   logic                 clock;
   logic                 reset;
   logic                 csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_W-1:0]     csr_wdata;

   vdf_req_if req_chan ();
   vdf_rsp_if rsp_chan ();

   vertical_difference_filter_core DUT (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Filter model state
   logic [CSR_W-1:0] luma_width_q    = LUMA_WIDTH_RESET;
   logic [CSR_W-1:0] luma_height_q   = LUMA_HEIGHT_RESET;
   logic [CSR_W-1:0] chroma_width_q  = CHROMA_WIDTH_RESET;
   logic [CSR_W-1:0] chroma_height_q = CHROMA_HEIGHT_RESET;
   logic [PIX_W-1:0] line_mem     [MAX_W];
   bit               line_written [MAX_W];
   int               column_pos = 0;
   int               row_pos    = 0;

   rsp_beat_type expected_beats [$];
   int           error_count   = 0;
   int           beats_checked = 0;
   int           pixels_sent   = 0;
   int           req_mode      = 0;

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   function automatic int eff_dim(input logic [CSR_W-1:0] v, input int lim);
      if (v == 0) return 1;
      if (v > lim) return lim;
      return v;
   endfunction

   // Resolve where the next pixel of this plane lands, wrapping stale counters.
   function automatic void locate_pixel(input logic [PLANE_W-1:0] plane, output int x,
                                        output int y, output int w, output int h);
      if (plane == PLANE_LUMA) begin
         w = eff_dim(luma_width_q, MAX_W);
         h = eff_dim(luma_height_q, MAX_H);
      end else begin
         w = eff_dim(chroma_width_q, MAX_W);
         h = eff_dim(chroma_height_q, MAX_H);
      end
      x = column_pos;
      y = row_pos;
      if (x >= w) begin
         x = 0;
         y++;
      end
      if (y >= h) y = 0;
   endfunction

   function automatic bit reads_unwritten(input logic [PLANE_W-1:0] plane);
      int x, y, w, h;
      locate_pixel(plane, x, y, w, h);
      return (y > 0) && !line_written[x];
   endfunction

   task automatic filter_pixel(input logic [PLANE_W-1:0] plane, input logic [PIX_W-1:0] pix,
                               input bit queue_results);
      int x, y, w, h, above, d;
      rsp_beat_type b;
      locate_pixel(plane, x, y, w, h);
      if (y > 0) begin
         above = line_mem[x];
         d = (above > pix) ? above - pix : pix - above;
         d += DIFF_OFFSET;
         if (d > PIX_MAX) d = PIX_MAX;
         b.pixel  = PIX_W'(d);
         b.plane  = plane;
         b.column = COORD_W'(x);
         b.row    = COORD_W'(y - 1);
         b.last   = (y != h - 1);
         if (queue_results) expected_beats.push_back(b);
      end
      if (y == h - 1) begin
         b.pixel  = pix;
         b.plane  = plane;
         b.column = COORD_W'(x);
         b.row    = COORD_W'(y);
         b.last   = 1'b1;
         if (queue_results) expected_beats.push_back(b);
      end
      line_mem[x]     = pix;
      line_written[x] = 1'b1;
      column_pos = x + 1;
      row_pos    = y;
      if (column_pos >= w) begin
         column_pos = 0;
         row_pos    = y + 1;
         if (row_pos >= h) row_pos = 0;
      end
   endtask

   function automatic int pick_gap(input int mode);
      int r;
      r = $urandom_range(0, 99);
      case (mode)
         0: return 0;
         1: begin
            if (r < 80) return 0;
            if (r < 97) return $urandom_range(1, 3);
            return $urandom_range(8, 40);
         end
         default: begin
            if (r < 40) return 0;
            if (r < 90) return $urandom_range(1, 4);
            return $urandom_range(10, 40);
         end
      endcase
   endfunction

   function automatic logic [PIX_W-1:0] rand_pixel();
      if ($urandom_range(0, 7) == 0) return $urandom_range(0, 1) ? 8'hFF : 8'h00;
      return PIX_W'($urandom_range(0, 255));
   endfunction

   // Offer one beat; return at the edge that accepts it, valid still high.
   task automatic drive_pixel(input logic [PLANE_W-1:0] plane, input logic [PIX_W-1:0] pix);
      int gap;
      gap = pick_gap(req_mode);
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid       <= 1'b1;
      req_chan.plane_index <= plane;
      req_chan.pixel_in    <= pix;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
   endtask

   task automatic send_pixel(input logic [PLANE_W-1:0] plane, input logic [PIX_W-1:0] pix);
      filter_pixel(plane, pix, 1'b1);
      drive_pixel(plane, pix);
      pixels_sent++;
   endtask

   // Drop valid and wait until the block has drained.
   task automatic wait_idle();
      req_chan.valid <= 1'b0;
      while (expected_beats.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input csr_index_type idx, input logic [CSR_W-1:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
      case (idx)
         CSR_LUMA_WIDTH:    luma_width_q    = val;
         CSR_LUMA_HEIGHT:   luma_height_q   = val;
         CSR_CHROMA_WIDTH:  chroma_width_q  = val;
         CSR_CHROMA_HEIGHT: chroma_height_q = val;
         default: ;
      endcase
   endtask

   function automatic logic [CSR_W-1:0] extreme_value();
      case ($urandom_range(0, 4))
         0: return CSR_W'(0);
         1: return CSR_W'(1);
         2: return CSR_W'(MAX_W);
         3: return CSR_W'(MAX_W + 1);
         default: return {CSR_W{1'b1}};
      endcase
   endfunction

   // Stimulus
   initial begin
      stim_row_type       row;
      logic [PLANE_W-1:0] pl;
      bit                 blocked;
      int                 i, k, f, p, n, kind, frames;

      reset                <= 1'b1;
      req_chan.valid       <= 1'b0;
      req_chan.plane_index <= PLANE_LUMA;
      req_chan.pixel_in    <= '0;
      csr_we               <= 1'b0;
      csr_index            <= CSR_LUMA_WIDTH;
      csr_wdata            <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (i = 0; i < DIR_ROWS; i++) begin
         row = directed_rows[i];
         if (row.kind == ROW_CSR) begin
            wait_idle();
            write_csr(row.csr_idx, row.csr_val);
         end else begin
            filter_pixel(row.plane, row.pixel, !row.typed);
            if (row.typed && row.n_typed >= 1) expected_beats.push_back(row.first_beat);
            if (row.typed && row.n_typed == 2) expected_beats.push_back(row.second_beat);
            drive_pixel(row.plane, row.pixel);
         end
      end

      // Fill the line store over the columns the random frames use.
      wait_idle();
      write_csr(CSR_LUMA_WIDTH, CSR_W'(FILL_WIDTH));
      write_csr(CSR_LUMA_HEIGHT, CSR_W'(1));
      req_mode = 1;
      for (k = 0; k < FILL_WIDTH; k++) send_pixel(PLANE_LUMA, rand_pixel());

      while (pixels_sent < RANDOM_ITEMS) begin
         wait_idle();
         req_mode = $urandom_range(0, 2);
         blocked  = 1'b0;
         kind     = $urandom_range(0, 9);
         if (kind < 7) begin
            write_csr(CSR_LUMA_WIDTH, CSR_W'($urandom_range(1, 12)));
            write_csr(CSR_LUMA_HEIGHT, CSR_W'($urandom_range(1, 6)));
            write_csr(CSR_CHROMA_WIDTH, CSR_W'($urandom_range(1, 8)));
            write_csr(CSR_CHROMA_HEIGHT, CSR_W'($urandom_range(1, 5)));
            frames = $urandom_range(1, 2);
            for (f = 0; f < frames && !blocked; f++) begin
               for (p = 0; p < 3 && !blocked; p++) begin
                  pl = PLANE_W'(p);
                  if (pl == PLANE_CR && $urandom_range(0, 3) == 0) pl = PLANE_EXTRA;
                  if (pl == PLANE_LUMA)
                     n = eff_dim(luma_width_q, MAX_W) * eff_dim(luma_height_q, MAX_H);
                  else
                     n = eff_dim(chroma_width_q, MAX_W) * eff_dim(chroma_height_q, MAX_H);
                  for (k = 0; k < n && !blocked; k++) begin
                     if (reads_unwritten(pl)) blocked = 1'b1;
                     else send_pixel(pl, rand_pixel());
                  end
               end
            end
         end else begin
            if (kind < 9)
               write_csr(csr_index_type'($urandom_range(0, 3)), CSR_W'($urandom_range(1, 20)));
            else
               write_csr(csr_index_type'($urandom_range(0, 3)), extreme_value());
            n = $urandom_range(5, 50);
            for (k = 0; k < n && !blocked; k++) begin
               pl = PLANE_W'($urandom_range(0, 3));
               if (reads_unwritten(pl)) blocked = 1'b1;
               else send_pixel(pl, rand_pixel());
            end
         end
      end

      wait_idle();
      if (error_count == 0 && expected_beats.size() == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

   // Result side: random stalls plus one long hold-off to back the block up.
   initial begin
      int stall_left, cyc, rsp_mode;
      bit hold_done;
      stall_left = 0;
      cyc        = 0;
      rsp_mode   = 1;
      hold_done  = 1'b0;
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         cyc++;
         if (stall_left > 0) begin
            stall_left--;
            rsp_chan.ready <= 1'b0;
         end else if (!hold_done && beats_checked >= HOLD_AFTER) begin
            hold_done  = 1'b1;
            stall_left = HOLD_CYCLES;
            rsp_chan.ready <= 1'b0;
         end else begin
            if (cyc % 64 == 0) rsp_mode = $urandom_range(0, 2);
            stall_left = pick_gap(rsp_mode);
            if (stall_left > 0) begin
               stall_left--;
               rsp_chan.ready <= 1'b0;
            end else begin
               rsp_chan.ready <= 1'b1;
            end
         end
      end
   end

   task automatic report_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      error_count++;
   endtask

   always @(posedge clock) begin
      rsp_beat_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (expected_beats.size() == 0) begin
            $display("%0t: unexpected result beat, expected none, actual pixel %0h at (%0d,%0d)",
                     $time, rsp_chan.pixel_out, rsp_chan.column_out, rsp_chan.row_out);
            error_count++;
         end else begin
            want = expected_beats.pop_front();
            beats_checked++;
            if (rsp_chan.pixel_out !== want.pixel)
               report_field("pixel_out", want.pixel, rsp_chan.pixel_out);
            if (rsp_chan.plane_out !== want.plane)
               report_field("plane_out", want.plane, rsp_chan.plane_out);
            if (rsp_chan.column_out !== want.column)
               report_field("column_out", want.column, rsp_chan.column_out);
            if (rsp_chan.row_out !== want.row)
               report_field("row_out", want.row, rsp_chan.row_out);
            if (rsp_chan.last_of_run !== want.last)
               report_field("last_of_run", want.last, rsp_chan.last_of_run);
         end
      end
   end

   initial begin
      #(LIMIT_NS);
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule
